// ===== src/tone_sequence_player_top_assert.svh =====
// assertion macros for the tone sequence player
// included by the top module, which checks its own logic; expands to nothing under SYNTHESIS
`ifndef TONE_SEQUENCE_PLAYER_TOP_ASSERT_SVH
`define TONE_SEQUENCE_PLAYER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define TSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be true outside reset
`define TSP_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TSP_ASSERT(lbl, prop, msg)
`define TSP_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== src/tsp_pkg.sv =====
// shared types and constants of the tone sequence player
// used by the top module and the tone unit; depends on nothing
package tsp_pkg;

    // function codes of an input transaction
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_BEGIN  = 3'd1;
    localparam logic [2:0] FUNC_APPEND = 3'd2;
    localparam logic [2:0] FUNC_ABORT  = 3'd3;
    localparam logic [2:0] FUNC_END    = 3'd4;
    localparam logic [2:0] FUNC_STATUS = 3'd5;
    localparam logic [2:0] FUNC_TABLE  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_LENGTH = 2'd0;
    localparam logic [1:0] CFG_ERROR_NOTE     = 2'd1;
    localparam logic [1:0] CFG_ERROR_LENGTH   = 2'd2;

    // reset values
    localparam logic [7:0]  DEFAULT_LENGTH_RESET = 8'h08;
    localparam logic [7:0]  ERROR_NOTE_RESET     = 8'h30;
    localparam logic [7:0]  ERROR_LENGTH_RESET   = 8'h80;
    localparam logic [15:0] PERIOD_RESET         = 16'd10347;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  note_byte;
        logic [7:0]  length_byte;
        logic        note_received;
        logic [3:0]  table_index;
        logic [15:0] table_period;
    } tsp_in_t;

    typedef struct packed {
        logic [15:0] tone_period;
        logic [14:0] tone_duty;
        logic        sound_on;
        logic [7:0]  notes_left;
    } tsp_out_t;

    // tuning table write request from the sequencer
    typedef struct packed {
        logic        valid;
        logic [3:0]  index;
        logic [15:0] period;
    } tsp_table_wr_t;

endpackage

// ===== src/tsp_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// depends on nothing
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/tsp_tone_unit.sv =====
// tuning table and period lookup: table entry of the tone nibble shifted by the octave nibble
// depends on tsp_pkg
module tsp_tone_unit
    import tsp_pkg::*;
#(
    parameter int TONES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tsp_table_wr_t table_wr,
    input  logic [7:0]    note,
    output logic [15:0]   period
);

    localparam int TW = (TONES > 1) ? $clog2(TONES) : 1;
    localparam logic [4:0] TONES5 = 5'(TONES);

    logic [15:0] table_reg [TONES];
    logic [3:0]  tone;
    logic [3:0]  shift;
    logic [15:0] base;

    // table writes, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TONES; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (table_wr.valid && ({1'b0, table_wr.index} < TONES5))
        begin
            table_reg[table_wr.index[TW-1:0]] <= table_wr.period;
        end
    end

    // lookup and octave shift
    assign tone  = note[3:0];
    assign shift = note[7:4];

    always_comb
    begin
        if ({1'b0, tone} < TONES5)
        begin
            base = table_reg[tone[TW-1:0]];
        end
        else
        begin
            base = '0;
        end
        period = base >> shift;
    end

endmodule

// ===== src/tone_sequence_player_top.sv =====
// Tone sequence player: input transactions on in_valid/in_stall carry tick,
// begin, append, abort, end, status and table write commands; every accepted
// transaction yields exactly one result transaction on out_valid/out_stall
// with the tone period, duty, sound enable and notes left after the command.
// Configuration (default length, error note, error length) is written through
// cfg_write_enable/cfg_index/cfg_data, by the user only while the block is idle; the block does not enforce it.
// One item is in work at a time; in_stall is high until its result is loaded
// into the output register. From accept, most items go straight to the done
// state; a tick that starts the next note passes through the load state, an
// append that completes a message through advance and load, and an abort or
// end message through cut, advance and load (advance skips load when the count
// wraps to an empty list). Notes and lengths live in two rams with a registered
// read; playing a note costs one read, and a cut-short message costs one more
// write for the error entry. A stalled receiver does not block the current
// accept, but holds its result in the done state, and in_stall with it.
// Reset clears all control state, the tuning table and the configuration to
// their defaults; the note and length rams are not cleared.
// depends on tsp_pkg, tsp_ram, tsp_tone_unit and the assertion header
`include "tone_sequence_player_top_assert.svh"
module tone_sequence_player_top
    import tsp_pkg::*;
#(
    parameter int ENTRIES = 256,
    parameter int TONES   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  tsp_in_t    in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output tsp_out_t   out_data,
    input  logic       cfg_write_enable,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam logic [11:0] ENT12 = 12'(ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CUT2 = 5'b00010,
        ST_ADV  = 5'b00100,
        ST_LOAD = 5'b01000,
        ST_DONE = 5'b10000
    } tsp_state_t;

    // store address: 8-bit count reduced modulo the store depth (for depths of at least 16)
    function automatic logic [AW-1:0] store_addr(input logic [7:0] v);
        logic [11:0] r;
        r = {4'b0, v};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (ENT12 << k))
            begin
                r = r - (ENT12 << k);
            end
        end
        return r[AW-1:0];
    endfunction

    tsp_state_t  state_reg, state_next;
    logic [7:0]  entry_count_reg, entry_count_next;
    logic [7:0]  play_index_reg, play_index_next;
    logic [7:0]  ticks_left_reg, ticks_left_next;
    logic [7:0]  entries_pending_reg, entries_pending_next;
    logic        receiving_reg, receiving_next;
    logic        sound_enable_reg, sound_enable_next;
    logic [15:0] period_reg, period_next;
    logic [7:0]  default_length_reg;
    logic [7:0]  error_note_reg;
    logic [7:0]  error_length_reg;
    logic        out_valid_reg;
    tsp_out_t    out_data_reg;

    logic          in_accept;
    logic          out_load;
    logic          adv_fetch;
    logic          note_we;
    logic          len_we;
    logic [7:0]    note_wdata;
    logic [7:0]    len_wdata;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    note_rdata;
    logic [7:0]    len_rdata;
    logic [15:0]   lookup_period;
    tsp_table_wr_t table_wr;
    tsp_out_t      result;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign adv_fetch = (play_index_reg < entry_count_reg);
    assign waddr     = store_addr(entry_count_reg);
    assign raddr     = store_addr(play_index_reg);

    // note and length stores
    tsp_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_note_ram (
        .clk   (clk),
        .we    (note_we),
        .waddr (waddr),
        .wdata (note_wdata),
        .raddr (raddr),
        .rdata (note_rdata)
    );

    tsp_ram #(.WIDTH(8), .DEPTH(ENTRIES)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (waddr),
        .wdata (len_wdata),
        .raddr (raddr),
        .rdata (len_rdata)
    );

    // tuning table and period computation
    tsp_tone_unit #(.TONES(TONES)) u_tone (
        .clk      (clk),
        .rst_n    (rst_n),
        .table_wr (table_wr),
        .note     (note_rdata),
        .period   (lookup_period)
    );

    // sequencer next state
    always_comb
    begin
        state_next           = state_reg;
        entry_count_next     = entry_count_reg;
        play_index_next      = play_index_reg;
        ticks_left_next      = ticks_left_reg;
        entries_pending_next = entries_pending_reg;
        receiving_next       = receiving_reg;
        sound_enable_next    = sound_enable_reg;
        period_next          = period_reg;
        note_we              = 1'b0;
        len_we               = 1'b0;
        note_wdata           = in_data.note_byte;
        len_wdata            = in_data.length_byte;
        table_wr             = '0;
        out_load             = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DONE;
                    case (in_data.func)
                        FUNC_TICK:
                        begin
                            if (!receiving_reg && (entry_count_reg != 8'd0))
                            begin
                                ticks_left_next = ticks_left_reg - 8'd1;
                                // expiry: start the next note or empty the list
                                if (ticks_left_reg == 8'd1)
                                begin
                                    if (adv_fetch)
                                    begin
                                        state_next = ST_LOAD;
                                    end
                                    else
                                    begin
                                        entry_count_next  = 8'd0;
                                        play_index_next   = 8'd0;
                                        sound_enable_next = 1'b0;
                                    end
                                end
                            end
                        end
                        FUNC_BEGIN:
                        begin
                            sound_enable_next    = 1'b0;
                            entry_count_next     = 8'd0;
                            play_index_next      = 8'd0;
                            entries_pending_next = in_data.length_byte;
                            receiving_next       = (in_data.length_byte != 8'd0);
                        end
                        FUNC_APPEND:
                        begin
                            if (receiving_reg)
                            begin
                                note_we              = 1'b1;
                                len_we               = 1'b1;
                                entry_count_next     = entry_count_reg + 8'd1;
                                entries_pending_next = entries_pending_reg - 8'd1;
                                if (entries_pending_reg == 8'd1)
                                begin
                                    receiving_next = 1'b0;
                                    state_next     = ST_ADV;
                                end
                            end
                        end
                        FUNC_ABORT, FUNC_END:
                        begin
                            // message cut short: current entry gets the default length
                            if (receiving_reg)
                            begin
                                note_we          = in_data.note_received;
                                len_we           = 1'b1;
                                len_wdata        = default_length_reg;
                                entry_count_next = entry_count_reg + 8'd1;
                                state_next       = ST_CUT2;
                            end
                        end
                        FUNC_TABLE:
                        begin
                            table_wr.valid  = 1'b1;
                            table_wr.index  = in_data.table_index;
                            table_wr.period = in_data.table_period;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CUT2:
            begin
                // append the error entry
                note_we              = 1'b1;
                len_we               = 1'b1;
                note_wdata           = error_note_reg;
                len_wdata            = error_length_reg;
                entry_count_next     = entry_count_reg + 8'd1;
                entries_pending_next = 8'd0;
                receiving_next       = 1'b0;
                state_next           = ST_ADV;
            end
            ST_ADV:
            begin
                if (adv_fetch)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    entry_count_next  = 8'd0;
                    play_index_next   = 8'd0;
                    sound_enable_next = 1'b0;
                    state_next        = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                // store read data is valid: start the note
                period_next       = lookup_period;
                ticks_left_next   = len_rdata;
                sound_enable_next = 1'b1;
                play_index_next   = play_index_reg + 8'd1;
                state_next        = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result from the settled state
    always_comb
    begin
        result.tone_period = period_reg;
        result.tone_duty   = period_reg[15:1];
        result.sound_on    = sound_enable_reg;
        if (entry_count_reg == 8'd0)
        begin
            result.notes_left = 8'd0;
        end
        else
        begin
            result.notes_left = entry_count_reg - play_index_reg + 8'd1;
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            entry_count_reg     <= '0;
            play_index_reg      <= '0;
            ticks_left_reg      <= '0;
            entries_pending_reg <= '0;
            receiving_reg       <= 1'b0;
            sound_enable_reg    <= 1'b0;
            period_reg          <= PERIOD_RESET;
        end
        else
        begin
            state_reg           <= state_next;
            entry_count_reg     <= entry_count_next;
            play_index_reg      <= play_index_next;
            ticks_left_reg      <= ticks_left_next;
            entries_pending_reg <= entries_pending_next;
            receiving_reg       <= receiving_next;
            sound_enable_reg    <= sound_enable_next;
            period_reg          <= period_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_length_reg <= DEFAULT_LENGTH_RESET;
            error_note_reg     <= ERROR_NOTE_RESET;
            error_length_reg   <= ERROR_LENGTH_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_DEFAULT_LENGTH: default_length_reg <= cfg_data;
                CFG_ERROR_NOTE:     error_note_reg     <= cfg_data;
                CFG_ERROR_LENGTH:   error_length_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // output register, one result transaction per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `TSP_ASSERT(a_accept_busy, in_accept |=> (state_reg != ST_IDLE), "accepted item left fsm idle")
    `TSP_ASSERT(a_load_sets_valid, out_load |=> out_valid_reg, "result register not loaded")
    `TSP_ASSERT_NEVER(a_sound_empty, sound_enable_reg && ((entry_count_reg == 8'd0) || (play_index_reg == 8'd0)), "sound on with empty list")
    `TSP_ASSERT_NEVER(a_recv_quiet, receiving_reg && (sound_enable_reg || (play_index_reg != 8'd0)), "playing while receiving")
    `TSP_ASSERT(a_load_origin, (state_reg == ST_LOAD) |-> (($past(state_reg) == ST_IDLE) || ($past(state_reg) == ST_ADV)), "store read not issued")

endmodule
